// File: sv/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, codes, constant tables and helper functions for the integer literal
// parser: suffix table, powers of ten, digit decoding and suffix packing.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam logic [2:0] RADIX_AUTO = 3'd0;
    localparam logic [2:0] RADIX_BIN  = 3'd1;
    localparam logic [2:0] RADIX_OCT  = 3'd2;
    localparam logic [2:0] RADIX_DEC  = 3'd3;
    localparam logic [2:0] RADIX_HEX  = 3'd4;

    localparam logic CFG_RADIX_MODE  = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    localparam int SUFFIX_COUNT = 13;

    localparam logic [63:0] MAX_U64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_U32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [46:0] MULT_US = 47'd1000;
    localparam logic [46:0] MULT_MS = 47'd1000000;
    localparam logic [46:0] MULT_S  = 47'd1000000000;
    localparam logic [46:0] MULT_M  = 47'd60000000000;
    localparam logic [46:0] MULT_H  = 47'd3600000000000;
    localparam logic [46:0] MULT_D  = 47'd86400000000000;

    localparam logic [63:0] QUOT_US = MAX_U64 / {17'd0, MULT_US};
    localparam logic [63:0] QUOT_MS = MAX_U64 / {17'd0, MULT_MS};
    localparam logic [63:0] QUOT_S  = MAX_U64 / {17'd0, MULT_S};
    localparam logic [63:0] QUOT_M  = MAX_U64 / {17'd0, MULT_M};
    localparam logic [63:0] QUOT_H  = MAX_U64 / {17'd0, MULT_H};
    localparam logic [63:0] QUOT_D  = MAX_U64 / {17'd0, MULT_D};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_DIGITS = 3'd1,
        ST_BAD_COEF  = 3'd2,
        ST_BAD_TRAIL = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [23:0] code;
        logic [63:0] quot;
        logic [46:0] mult;
    } suffix_entry_t;

    typedef struct packed {
        logic [23:0] chars;
        logic [2:0]  len;
    } suffix_buf_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } suffix_hit_t;

    // literal snapshot taken on the last character
    typedef struct packed {
        logic [63:0] acc;
        logic        ovf;
        logic        digit_seen;
        logic [4:0]  exp_count;
        suffix_buf_t sfx;
        logic        neg;
        logic        sgn;
    } snap_t;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        suffix_hit_t sfx;
        logic        neg;
        logic        sgn;
    } scaled_t;

    typedef struct packed {
        logic [63:0] pp_ll;
        logic [46:0] pp_lh;
        logic [63:0] pp_hl;
        status_t     status;
        logic        neg;
        logic        sgn;
    } partial_t;

    typedef struct packed {
        logic [63:0] prod;
        status_t     status;
        logic        neg;
        logic        sgn;
    } product_t;

    function automatic logic [2:0] radix_from_mode(input logic [2:0] mode);
        logic [2:0] r;
        r = (mode <= RADIX_HEX) ? mode : RADIX_DEC;
        return r;
    endfunction

    function automatic logic [23:0] pack3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        return {c, b, a};
    endfunction

    function automatic suffix_entry_t suffix_entry(input logic [3:0] idx);
        suffix_entry_t e;
        case (idx)
            4'd0:    e = '{3'd0, 24'd0, MAX_U64, 47'd1};
            4'd1:    e = '{3'd1, pack3("u", 8'd0, 8'd0), MAX_U32, 47'd1};
            4'd2:    e = '{3'd2, pack3("u", "l", 8'd0), MAX_U64, 47'd1};
            4'd3:    e = '{3'd3, pack3("u", "l", "l"), MAX_U64, 47'd1};
            4'd4:    e = '{3'd1, pack3("l", 8'd0, 8'd0), MAX_S64, 47'd1};
            4'd5:    e = '{3'd2, pack3("l", "l", 8'd0), MAX_S64, 47'd1};
            4'd6:    e = '{3'd2, pack3("n", "s", 8'd0), MAX_U64, 47'd1};
            4'd7:    e = '{3'd2, pack3("u", "s", 8'd0), QUOT_US, MULT_US};
            4'd8:    e = '{3'd2, pack3("m", "s", 8'd0), QUOT_MS, MULT_MS};
            4'd9:    e = '{3'd1, pack3("s", 8'd0, 8'd0), QUOT_S, MULT_S};
            4'd10:   e = '{3'd1, pack3("m", 8'd0, 8'd0), QUOT_M, MULT_M};
            4'd11:   e = '{3'd1, pack3("h", 8'd0, 8'd0), QUOT_H, MULT_H};
            4'd12:   e = '{3'd1, pack3("d", 8'd0, 8'd0), QUOT_D, MULT_D};
            default: e = '{3'd7, 24'd0, MAX_U64, 47'd1};
        endcase
        return e;
    endfunction

    function automatic suffix_hit_t suffix_lookup(input suffix_buf_t sfx);
        suffix_hit_t   h;
        suffix_entry_t e;
        h = '{1'b0, 4'd0};
        for (int i = SUFFIX_COUNT - 1; i >= 0; i--) begin
            e = suffix_entry(4'(i));
            if (e.len == sfx.len && e.code == sfx.chars) begin
                h = '{1'b1, 4'(i)};
            end
        end
        return h;
    endfunction

    function automatic logic [63:0] pow10(input logic [4:0] k);
        logic [63:0] p;
        case (k)
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            5'd19:   p = 64'd10000000000000000000;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

    function automatic digit_t digit_decode(input logic [7:0] c, input logic [2:0] radix);
        digit_t     d;
        logic [4:0] base;
        logic [7:0] raw;
        logic       is_digit;
        case (radix)
            RADIX_BIN: base = 5'd2;
            RADIX_OCT: base = 5'd8;
            RADIX_HEX: base = 5'd16;
            default:   base = 5'd10;
        endcase
        is_digit = 1'b1;
        raw      = 8'd0;
        if (c >= "0" && c <= "9") begin
            raw = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            raw = c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            raw = c - 8'h37;
        end else begin
            is_digit = 1'b0;
        end
        d.ok    = is_digit && ({3'd0, raw[4:0]} < {3'd0, base});
        d.value = raw[3:0];
        return d;
    endfunction

    function automatic suffix_buf_t suffix_push(input suffix_buf_t s, input logic [7:0] c);
        suffix_buf_t r;
        r = s;
        if (s.len < 3'd3) begin
            case (s.len[1:0])
                2'd0:    r.chars[7:0]   = c;
                2'd1:    r.chars[15:8]  = c;
                default: r.chars[23:16] = c;
            endcase
            r.len = s.len + 3'd1;
        end else begin
            r.len = 3'd4;
        end
        return r;
    endfunction

endpackage

// File: sv/integer_literal_parser_unit.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_unit
// Streaming integer literal parser: radix prefixes, digit accumulation,
// decimal exponent, type and time suffixes, signed range handling.
// ----------------------------------------------------------------------------
// One character is taken per clock while s_tready is high; the accumulator
// shift-add with its overflow check is the per-character step and allows a
// new character every cycle. After the character marked with s_tlast, the
// value and status pass a finishing pipeline (exponent scaling and suffix
// lookup, suffix range check and multiply split into 32-bit partial
// products, partial-product sum, sign handling) through the snapshot, stage
// and output registers to the m_ side. Backpressure on m_tready stalls the
// pipeline stage by stage; s_tready drops only when the pipeline is full.
module integer_literal_parser_unit
    import ilp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_literal
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [66:64] status, [71:67] zero
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_LEAD,
        PH_ZERO,
        PH_DIGITS,
        PH_EXPO,
        PH_SUFFIX
    } phase_t;

    logic [2:0]  radix_mode_reg;
    logic        signed_mode_reg;

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        digit_reg, digit_next;
    logic [2:0]  radix_reg, radix_next;
    logic [4:0]  exp_reg, exp_next;
    suffix_buf_t sfx_reg, sfx_next;
    logic        neg_reg, neg_next;
    logic        epend_reg, epend_next;

    logic        skip, do_digit;
    digit_t      dv;
    logic [67:0] acc_wide, mac;
    logic [7:0]  exp_wide;
    snap_t       snap_next;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    snap_t       s1_reg;
    scaled_t     s2_reg, s2_next;
    partial_t    s3_reg, s3_next;
    product_t    s4_reg, s4_next;
    logic [63:0] value_next;
    status_t     status_next;
    logic        r1, r2, r3, r4, out_ready;
    logic        accept;

    logic [67:0]   exp_prod;
    suffix_entry_t sent;
    logic [31:0]   mid;

    assign out_ready = !m_tvalid || m_tready;
    assign r4        = !v4_reg || out_ready;
    assign r3        = !v3_reg || r4;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign s_tready  = r1;
    assign accept    = s_tvalid && s_tready;

    // per-character step
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        digit_next = digit_reg;
        radix_next = radix_reg;
        exp_next   = exp_reg;
        sfx_next   = sfx_reg;
        neg_next   = neg_reg;
        epend_next = epend_reg;
        skip       = 1'b0;
        do_digit   = 1'b0;
        exp_wide   = 8'd0;

        if (phase_reg == PH_FIRST) begin
            radix_next = radix_from_mode(radix_mode_reg);
            phase_next = PH_LEAD;
            if (signed_mode_reg && s_tdata == "-") begin
                neg_next = 1'b1;
                skip     = 1'b1;
            end
        end

        if (!skip && s_tdata != "_") begin
            case (phase_next)
                PH_LEAD: begin
                    if (radix_next == RADIX_AUTO && s_tdata == "0") begin
                        digit_next = 1'b1;
                        acc_next   = 64'd0;
                        radix_next = RADIX_OCT;
                        phase_next = PH_ZERO;
                    end else begin
                        if (radix_next == RADIX_AUTO) begin
                            radix_next = RADIX_DEC;
                        end
                        phase_next = PH_DIGITS;
                        do_digit   = 1'b1;
                    end
                end
                PH_ZERO: begin
                    phase_next = PH_DIGITS;
                    if (s_tdata == "x" || s_tdata == "X") begin
                        radix_next = RADIX_HEX;
                        digit_next = 1'b0;
                    end else if (s_tdata == "b" || s_tdata == "B") begin
                        radix_next = RADIX_BIN;
                        digit_next = 1'b0;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                PH_EXPO: begin
                    if (s_tdata >= "0" && s_tdata <= "9") begin
                        exp_wide = {3'd0, exp_reg} * 8'd10 + (s_tdata - 8'h30);
                        exp_next = (exp_wide > 8'd20) ? 5'd20 : exp_wide[4:0];
                    end else begin
                        sfx_next   = suffix_push(sfx_reg, s_tdata);
                        phase_next = PH_SUFFIX;
                    end
                end
                default: begin
                    sfx_next = suffix_push(sfx_reg, s_tdata);
                end
            endcase
        end

        dv       = digit_decode(s_tdata, radix_next);
        acc_wide = {4'd0, acc_reg};
        case (radix_next)
            RADIX_BIN: mac = (acc_wide << 1) + {64'd0, dv.value};
            RADIX_OCT: mac = (acc_wide << 3) + {64'd0, dv.value};
            RADIX_HEX: mac = (acc_wide << 4) + {64'd0, dv.value};
            default:   mac = (acc_wide << 3) + (acc_wide << 1) + {64'd0, dv.value};
        endcase

        if (do_digit) begin
            if (epend_reg) begin
                epend_next = 1'b0;
                if (s_tdata >= "1" && s_tdata <= "9") begin
                    phase_next = PH_EXPO;
                    exp_next   = 5'(s_tdata - 8'h30);
                end else begin
                    sfx_next   = suffix_push(suffix_push(sfx_reg, "e"), s_tdata);
                    phase_next = PH_SUFFIX;
                end
            end else if (dv.ok) begin
                digit_next = 1'b1;
                if (!ovf_reg) begin
                    if (mac[67:64] != 4'd0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = mac[63:0];
                    end
                end
            end else if (digit_next && (s_tdata == "e" || s_tdata == "E")) begin
                epend_next = 1'b1;
            end else begin
                sfx_next   = suffix_push(sfx_reg, s_tdata);
                phase_next = PH_SUFFIX;
            end
        end

        snap_next.acc        = acc_next;
        snap_next.ovf        = ovf_next;
        snap_next.digit_seen = digit_next;
        snap_next.exp_count  = exp_next;
        snap_next.sfx        = epend_next ? suffix_push(sfx_next, "e") : sfx_next;
        snap_next.neg        = neg_next;
        snap_next.sgn        = signed_mode_reg;
    end

    // exponent scaling, suffix lookup
    always_comb begin
        exp_prod = {4'd0, pow10(s1_reg.exp_count)} * {64'd0, s1_reg.acc[3:0]};
        s2_next.value  = (s1_reg.exp_count != 5'd0) ? exp_prod[63:0] : s1_reg.acc;
        s2_next.sfx    = suffix_lookup(s1_reg.sfx);
        s2_next.neg    = s1_reg.neg;
        s2_next.sgn    = s1_reg.sgn;
        if (!s1_reg.digit_seen) begin
            s2_next.status = ST_NO_DIGITS;
        end else if (s1_reg.ovf) begin
            s2_next.status = ST_OVERFLOW;
        end else if (s1_reg.exp_count != 5'd0 &&
                     (s1_reg.acc[63:4] != 60'd0 || s1_reg.acc[3:0] == 4'd0 ||
                      s1_reg.acc[3:0] > 4'd9)) begin
            s2_next.status = ST_BAD_COEF;
        end else if (s1_reg.exp_count >= 5'd20 ||
                     (s1_reg.exp_count != 5'd0 && exp_prod[67:64] != 4'd0)) begin
            s2_next.status = ST_OVERFLOW;
        end else begin
            s2_next.status = ST_OK;
        end
    end

    // suffix range check and partial products
    always_comb begin
        sent = suffix_entry(s2_reg.sfx.idx);
        s3_next.pp_ll  = {32'd0, s2_reg.value[31:0]} * {32'd0, sent.mult[31:0]};
        s3_next.pp_lh  = {15'd0, s2_reg.value[31:0]} * {32'd0, sent.mult[46:32]};
        s3_next.pp_hl  = {32'd0, s2_reg.value[63:32]} * {32'd0, sent.mult[31:0]};
        s3_next.neg    = s2_reg.neg;
        s3_next.sgn    = s2_reg.sgn;
        s3_next.status = s2_reg.status;
        if (s2_reg.status == ST_OK) begin
            if (!s2_reg.sfx.hit) begin
                s3_next.status = ST_BAD_TRAIL;
            end else if (s2_reg.value > sent.quot) begin
                s3_next.status = ST_OVERFLOW;
            end
        end
    end

    // partial product sum
    always_comb begin
        mid            = s3_reg.pp_lh[31:0] + s3_reg.pp_hl[31:0];
        s4_next.prod   = s3_reg.pp_ll + {mid, 32'd0};
        s4_next.status = s3_reg.status;
        s4_next.neg    = s3_reg.neg;
        s4_next.sgn    = s3_reg.sgn;
    end

    // sign handling
    always_comb begin
        status_next = s4_reg.status;
        value_next  = s4_reg.prod;
        if (s4_reg.status == ST_OK) begin
            if (s4_reg.neg) begin
                if (s4_reg.prod[63] && s4_reg.prod[62:0] != 63'd0) begin
                    status_next = ST_OVERFLOW;
                end
                value_next = 64'd0 - s4_reg.prod;
            end else if (s4_reg.sgn && s4_reg.prod[63]) begin
                status_next = ST_OVERFLOW;
            end
        end
        if (status_next != ST_OK) begin
            value_next = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_mode_reg  <= RADIX_AUTO;
            signed_mode_reg <= 1'b0;
            phase_reg       <= PH_FIRST;
            acc_reg         <= 64'd0;
            ovf_reg         <= 1'b0;
            digit_reg       <= 1'b0;
            radix_reg       <= RADIX_AUTO;
            exp_reg         <= 5'd0;
            sfx_reg         <= '0;
            neg_reg         <= 1'b0;
            epend_reg       <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            m_tvalid        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RADIX_MODE:  radix_mode_reg  <= cfg_wdata;
                    CFG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                    default:         radix_mode_reg  <= radix_mode_reg;
                endcase
            end
            if (accept) begin
                if (s_tlast) begin
                    phase_reg <= PH_FIRST;
                    acc_reg   <= 64'd0;
                    ovf_reg   <= 1'b0;
                    digit_reg <= 1'b0;
                    radix_reg <= radix_from_mode(radix_mode_reg);
                    exp_reg   <= 5'd0;
                    sfx_reg   <= '0;
                    neg_reg   <= 1'b0;
                    epend_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    ovf_reg   <= ovf_next;
                    digit_reg <= digit_next;
                    radix_reg <= radix_next;
                    exp_reg   <= exp_next;
                    sfx_reg   <= sfx_next;
                    neg_reg   <= neg_next;
                    epend_reg <= epend_next;
                end
            end
            if (r1) begin
                v1_reg <= accept && s_tlast;
                s1_reg <= snap_next;
            end
            if (r2) begin
                v2_reg <= v1_reg;
                s2_reg <= s2_next;
            end
            if (r3) begin
                v3_reg <= v2_reg;
                s3_reg <= s3_next;
            end
            if (r4) begin
                v4_reg <= v3_reg;
                s4_reg <= s4_next;
            end
            if (out_ready) begin
                m_tvalid <= v4_reg;
                m_tdata  <= {5'd0, status_next, value_next};
            end
        end
    end

    a_error_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66:64] != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("error status with nonzero value");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[66:64] <= ST_OVERFLOW && m_tdata[71:67] == 5'd0)
        else $error("status code out of range");

    a_suffix_len: assert property (@(posedge aclk) disable iff (!aresetn)
        sfx_reg.len <= 3'd4 && exp_reg <= 5'd20)
        else $error("suffix length or exponent count beyond saturation");

    a_literal_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> phase_reg == PH_FIRST && v1_reg)
        else $error("last character did not restart the literal");

endmodule

// File: tb/sv/integer_literal_parser_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_unit_checker
// Watches the character and result channels of the literal parser. It keeps
// its own copy of the registers and of the per-literal parse state, works out
// the value and status due on each closing character and compares them with
// the results, in order.
// ----------------------------------------------------------------------------
module integer_literal_parser_unit_checker
    import ilp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_literal
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [63:0] value, [66:64] status, [71:67] zero
    output int          mismatch_count,
    output int          outstanding
);

    typedef enum logic [2:0] {
        LIT_FIRST,
        LIT_LEAD,
        LIT_ZERO,
        LIT_DIGITS,
        LIT_EXPO,
        LIT_SUFFIX
    } lit_phase_t;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
    } literal_result_t;

    literal_result_t expected_literals[$];

    logic [2:0]  radix_reg;
    logic        signed_reg;

    lit_phase_t  phase;
    logic [63:0] acc;
    logic        acc_ovf;
    logic        have_digit;
    logic [2:0]  radix_now;
    logic [4:0]  exp_val;
    logic [23:0] sfx_chars;
    logic [2:0]  sfx_len;
    logic        minus;
    logic        e_pending;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_literal();
        phase      = LIT_FIRST;
        acc        = '0;
        acc_ovf    = 1'b0;
        have_digit = 1'b0;
        radix_now  = (radix_reg <= RADIX_HEX) ? radix_reg : RADIX_DEC;
        exp_val    = '0;
        sfx_chars  = '0;
        sfx_len    = '0;
        minus      = 1'b0;
        e_pending  = 1'b0;
    endtask

    function automatic logic [63:0] base_of(input logic [2:0] r);
        case (r)
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            RADIX_HEX: return 64'd16;
            default:   return 64'd10;
        endcase
    endfunction

    function automatic logic digit_of(input logic [7:0] c, input logic [63:0] base,
                                      output logic [63:0] d);
        int v;
        d = '0;
        if (c >= "0" && c <= "9") begin
            v = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h61 + 10;
        end else if (c >= "A" && c <= "F") begin
            v = c - 8'h41 + 10;
        end else begin
            return 1'b0;
        end
        d = 64'(v);
        return d < base;
    endfunction

    // suffix text -> extra upper bound and multiplier
    function automatic logic suffix_rule(input logic [2:0] len, input logic [23:0] code,
                                         output logic [63:0] limit, output logic [63:0] mult);
        limit = MAX_U64;
        mult  = 64'd1;
        case ({len, code})
            {3'd0, 24'h000000}: ;
            {3'd1, 24'h000075}: limit = MAX_U32;
            {3'd2, 24'h006C75}: ;
            {3'd3, 24'h6C6C75}: ;
            {3'd1, 24'h00006C}: limit = MAX_S64;
            {3'd2, 24'h006C6C}: limit = MAX_S64;
            {3'd2, 24'h00736E}: ;
            {3'd2, 24'h007375}: mult = 64'd1000;
            {3'd2, 24'h00736D}: mult = 64'd1000000;
            {3'd1, 24'h000073}: mult = 64'd1000000000;
            {3'd1, 24'h00006D}: mult = 64'd60000000000;
            {3'd1, 24'h000068}: mult = 64'd3600000000000;
            {3'd1, 24'h000064}: mult = 64'd86400000000000;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic sfx_push(input logic [7:0] c);
        if (sfx_len < 3'd3) begin
            sfx_chars[sfx_len*8 +: 8] = c;
            sfx_len = sfx_len + 3'd1;
        end else begin
            sfx_len = 3'd4;
        end
    endtask

    task automatic digit_step(input logic [7:0] c);
        logic [63:0] base;
        logic [63:0] d;
        base = base_of(radix_now);
        if (e_pending) begin
            e_pending = 1'b0;
            if (c >= "1" && c <= "9") begin
                phase   = LIT_EXPO;
                exp_val = 5'(c - 8'h30);
                return;
            end
            sfx_push("e");
            sfx_push(c);
            phase = LIT_SUFFIX;
            return;
        end
        if (digit_of(c, base, d)) begin
            have_digit = 1'b1;
            if (!acc_ovf) begin
                if (acc > (MAX_U64 - d) / base) begin
                    acc_ovf = 1'b1;
                end else begin
                    acc = acc * base + d;
                end
            end
            return;
        end
        if (have_digit && (c == "e" || c == "E")) begin
            e_pending = 1'b1;
            return;
        end
        sfx_push(c);
        phase = LIT_SUFFIX;
    endtask

    task automatic take_char(input logic [7:0] c);
        int n;
        if (phase == LIT_FIRST) begin
            radix_now = (radix_reg <= RADIX_HEX) ? radix_reg : RADIX_DEC;
            phase     = LIT_LEAD;
            if (signed_reg && c == "-") begin
                minus = 1'b1;
                return;
            end
        end
        if (c == "_") begin
            return;
        end
        case (phase)
            LIT_LEAD: begin
                if (radix_now == RADIX_AUTO) begin
                    if (c == "0") begin
                        have_digit = 1'b1;
                        acc        = '0;
                        radix_now  = RADIX_OCT;
                        phase      = LIT_ZERO;
                        return;
                    end
                    radix_now = RADIX_DEC;
                end
                phase = LIT_DIGITS;
                digit_step(c);
            end
            LIT_ZERO: begin
                phase = LIT_DIGITS;
                if (c == "x" || c == "X") begin
                    radix_now  = RADIX_HEX;
                    have_digit = 1'b0;
                end else if (c == "b" || c == "B") begin
                    radix_now  = RADIX_BIN;
                    have_digit = 1'b0;
                end else begin
                    digit_step(c);
                end
            end
            LIT_DIGITS: digit_step(c);
            LIT_EXPO: begin
                if (c >= "0" && c <= "9") begin
                    n       = exp_val * 10 + (c - 8'h30);
                    exp_val = (n > 20) ? 5'd20 : 5'(n);
                end else begin
                    sfx_push(c);
                    phase = LIT_SUFFIX;
                end
            end
            default: sfx_push(c);
        endcase
    endtask

    task automatic finish_literal(output logic [63:0] val, output status_t st);
        logic [63:0] v;
        logic [63:0] lim;
        logic [63:0] mul;
        val = '0;
        v   = acc;
        if (e_pending) begin
            e_pending = 1'b0;
            sfx_push("e");
        end
        if (!have_digit) begin
            st = ST_NO_DIGITS;
            return;
        end
        if (acc_ovf) begin
            st = ST_OVERFLOW;
            return;
        end
        if (exp_val != 0) begin
            if (v < 64'd1 || v > 64'd9) begin
                st = ST_BAD_COEF;
                return;
            end
            if (exp_val >= 5'd20) begin
                st = ST_OVERFLOW;
                return;
            end
            for (int k = 0; k < exp_val; k++) begin
                if (v > MAX_U64 / 64'd10) begin
                    st = ST_OVERFLOW;
                    return;
                end
                v = v * 64'd10;
            end
        end
        if (!suffix_rule(sfx_len, sfx_chars, lim, mul)) begin
            st = ST_BAD_TRAIL;
            return;
        end
        if (v > lim / mul) begin
            st = ST_OVERFLOW;
            return;
        end
        v = v * mul;
        if (minus) begin
            if (v > 64'h8000_0000_0000_0000) begin
                st = ST_OVERFLOW;
                return;
            end
            v = 64'd0 - v;
        end else if (signed_reg) begin
            if (v > MAX_S64) begin
                st = ST_OVERFLOW;
                return;
            end
        end
        val = v;
        st  = ST_OK;
    endtask

    task automatic check_result();
        literal_result_t want;
        if (expected_literals.size() == 0) begin
            report_mismatch("result with no literal closed", m_tdata[63:0], '0);
            return;
        end
        want = expected_literals.pop_front();
        if (m_tdata[63:0] != want.value) begin
            report_mismatch("value", m_tdata[63:0], want.value);
        end
        if (m_tdata[66:64] != want.status) begin
            report_mismatch("status", 64'(m_tdata[66:64]), 64'(want.status));
        end
        if (m_tdata[71:67] != '0) begin
            report_mismatch("pad bits", 64'(m_tdata[71:67]), '0);
        end
    endtask

    task automatic accept_char();
        literal_result_t r;
        logic [63:0]     v;
        status_t         st;
        take_char(s_tdata);
        if (s_tlast) begin
            finish_literal(v, st);
            r.value  = v;
            r.status = st;
            expected_literals.push_back(r);
            clear_literal();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_literals.delete();
            mismatch_count = 0;
            radix_reg      = RADIX_AUTO;
            signed_reg     = 1'b0;
            clear_literal();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (s_tvalid && s_tready) begin
                accept_char();
            end
            if (cfg_we) begin
                if (cfg_index == CFG_RADIX_MODE) begin
                    radix_reg = cfg_wdata;
                end else begin
                    signed_reg = cfg_wdata[0];
                end
            end
        end
        outstanding = expected_literals.size();
    end

endmodule

// File: tb/sv/integer_literal_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_unit_tb
// Feeds literal text to the parser one character per transaction: a directed
// set of edge literals under several register settings, then random literals,
// mostly well formed, some corrupted, some pure noise. Both channels idle at
// random; the result side also holds off for a long stretch. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module integer_literal_parser_unit_tb;
    import ilp_pkg::*;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int LATENCY_CYCLES = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_CHARS   = 470;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    int          mismatch_count;
    int          outstanding;
    int          cycle_count = 0;
    int          sent_chars;
    bit          hold_req = 1'b0;
    bit          hold_issued = 1'b0;
    bit          calm = 1'b0;
    logic [2:0]  cur_radix;
    logic        cur_signed;
    logic [7:0]  text_q[$];

    integer_literal_parser_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    integer_literal_parser_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("integer_literal_parser_unit_tb failed");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 27);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= !idle_now();
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge aclk);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
    endtask

    task automatic send_text(input bit close = 1'b1);
        foreach (text_q[i]) begin
            send_char(text_q[i], close && (i == text_q.size() - 1));
        end
        sent_chars += text_q.size();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic send_str(input string s, input bit close = 1'b1);
        text_q.delete();
        add_text(s);
        send_text(close);
    endtask

    // wait until every result is out, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RADIX_MODE) begin
            cur_radix = data;
        end else begin
            cur_signed = data[0];
        end
    endtask

    task automatic configure(input logic [2:0] radix, input logic sgn);
        settle();
        write_reg(CFG_RADIX_MODE, radix);
        write_reg(CFG_SIGNED_MODE, {2'b00, sgn});
    endtask

    function automatic logic [7:0] digit_char(input logic [2:0] rad);
        int v;
        case (rad)
            RADIX_BIN: return 8'("0" + $urandom_range(1));
            RADIX_OCT: return 8'("0" + $urandom_range(7));
            RADIX_HEX: begin
                v = $urandom_range(15);
                if (v < 10) return 8'("0" + v);
                return $urandom_range(1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
            end
            default:   return 8'("0" + $urandom_range(9));
        endcase
    endfunction

    function automatic string suffix_text(input int i);
        case (i)
            0:       return "u";
            1:       return "ul";
            2:       return "ull";
            3:       return "l";
            4:       return "ll";
            5:       return "ns";
            6:       return "us";
            7:       return "ms";
            8:       return "s";
            9:       return "m";
            10:      return "h";
            11:      return "d";
            12:      return "U";
            13:      return "lll";
            14:      return "ux";
            default: return "msx";
        endcase
    endfunction

    function automatic string bound_text(input int i);
        case (i)
            0:       return "18446744073709551615";
            1:       return "18446744073709551616";
            2:       return "9223372036854775807";
            3:       return "-9223372036854775808";
            4:       return "4294967295u";
            5:       return "4294967296u";
            6:       return "18446744073709552us";
            default: return "213504d";
        endcase
    endfunction

    task automatic gen_literal();
        int         kind;
        int         ndig;
        logic [2:0] rad;
        text_q.delete();
        kind = $urandom_range(9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind == 1) begin
            add_text(bound_text($urandom_range(7)));
            return;
        end
        if (cur_signed && $urandom_range(2) == 0) add_text("-");
        rad = (cur_radix > RADIX_HEX) ? RADIX_DEC : cur_radix;
        if (rad == RADIX_AUTO) begin
            case ($urandom_range(3))
                0: begin
                    add_text($urandom_range(1) ? "0x" : "0X");
                    rad = RADIX_HEX;
                end
                1: begin
                    add_text($urandom_range(1) ? "0b" : "0B");
                    rad = RADIX_BIN;
                end
                2: begin
                    add_text("0");
                    rad = RADIX_OCT;
                end
                default: begin
                    text_q.push_back(8'("0" + $urandom_range(1, 9)));
                    rad = RADIX_DEC;
                end
            endcase
        end
        ndig = ($urandom_range(4) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 5);
        repeat (ndig) begin
            if ($urandom_range(7) == 0) add_text("_");
            text_q.push_back(digit_char(rad));
        end
        if ($urandom_range(4) == 0) begin
            add_text($urandom_range(1) ? "e" : "E");
            text_q.push_back(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) text_q.push_back(8'("0" + $urandom_range(9)));
        end
        if ($urandom_range(2) == 0) add_text(suffix_text($urandom_range(15)));
        if (text_q.size() == 0) add_text("_");
        if ($urandom_range(9) == 0) begin
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_RADIX_MODE;
        cfg_wdata  = RADIX_AUTO;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        cur_radix  = RADIX_AUTO;
        cur_signed = 1'b0;
        sent_chars = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: auto radix, unsigned
        configure(RADIX_AUTO, 1'b0);
        send_str("0");
        send_str("18446744073709551615");
        send_str("18446744073709551616");
        send_str("0x_FF");
        send_str("0B101");
        send_str("017");
        send_str("08");
        send_str("0x");
        send_str("0e5");
        send_str("1e19");
        send_str("2e19");
        send_str("3e25");
        send_str("5e");
        send_str("10us");
        send_str("2d");
        send_str("4294967296u");
        send_str("9223372036854775807ll");
        send_str("+5");
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();

        // signed decimal
        configure(RADIX_DEC, 1'b1);
        send_str("-9223372036854775808");
        send_str("-9223372036854775809");
        send_str("9223372036854775808");
        send_str("-0");
        send_str("5-");

        configure(RADIX_BIN, 1'b0);
        send_str("1_0_12");
        configure(RADIX_HEX, 1'b0);
        send_str("deadBEEFul");
        send_str("0x10");
        configure(3'd7, 1'b1);
        send_str("99ms");

        // register writes in the middle of a literal
        configure(RADIX_DEC, 1'b1);
        send_char("-", 1'b0);
        settle();
        write_reg(CFG_SIGNED_MODE, 3'd0);
        write_reg(CFG_RADIX_MODE, RADIX_HEX);
        send_char("1", 1'b0);
        send_char("0", 1'b1);
        configure(RADIX_DEC, 1'b0);
        send_str("9223372036854775808", 1'b0);
        settle();
        write_reg(CFG_SIGNED_MODE, 3'd1);
        send_char("_", 1'b1);

        // random literals
        sent_chars = 0;
        while (sent_chars < RANDOM_CHARS) begin
            if ($urandom_range(11) == 0) begin
                configure(3'($urandom_range(7)), 1'($urandom_range(1)));
            end
            if (!hold_issued && sent_chars > 150) begin
                hold_issued = 1'b1;
                hold_req    = 1'b1;
                repeat (24) send_str("7");
            end
            calm = (sent_chars >= 300) && (sent_chars < 420);
            gen_literal();
            send_text();
        end
        calm = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("integer_literal_parser_unit_tb passed");
        end else begin
            $display("integer_literal_parser_unit_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/ilp_pkg.sv
sv/integer_literal_parser_unit.sv
tb/sv/integer_literal_parser_unit_checker.sv
tb/sv/integer_literal_parser_unit_tb.sv
